@@ rtl/histogram_equalizer_defines.svh @@
// ----------------------------------------------------------------------------
// Histogram equalizer assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_EQUALIZER_DEFINES_SVH
`define HISTOGRAM_EQUALIZER_DEFINES_SVH

// Same-cycle implication, ignored while reset is held
`define HE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is held
`define HE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks across reset
`define HE_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/he_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer package
// Widths, action codes, controller states and color math helpers.
// ----------------------------------------------------------------------------
package he_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int PIX_AW     = $clog2(MAX_PIXELS);
  localparam int CNT_W      = PIX_AW + 1;
  localparam int LEVELS     = 256;
  localparam int LVL_W      = 8;
  localparam int NUM_W      = CNT_W + 9;
  localparam int DEN_W      = CNT_W + 1;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int COL_W      = 10;
  localparam int ACC_W      = 28;

  // Q16 coefficients
  localparam int LUMA_R = 19595;
  localparam int LUMA_G = 38470;
  localparam int LUMA_B = 7471;
  localparam int CU_R   = 11076;
  localparam int CU_G   = 21692;
  localparam int CU_B   = 32768;
  localparam int CV_R   = 32768;
  localparam int CV_G   = 27460;
  localparam int CV_B   = 5308;
  localparam int C_OFS  = 128 * 65536;
  localparam int R_V    = 74700;
  localparam int G_U    = 25864;
  localparam int G_V    = 38050;
  localparam int B_U    = 133176;
  localparam int MAP_K  = 2 * 255;

  typedef enum logic [1:0] {
    ACT_LOAD      = 2'd0,
    ACT_EMIT      = 2'd1,
    ACT_NEW_FRAME = 2'd2
  } action_t;

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b00000000001,
    ST_LD_BIN  = 11'b00000000010,
    ST_BLD_RD  = 11'b00000000100,
    ST_BLD_ACC = 11'b00000001000,
    ST_BLD_NUM = 11'b00000010000,
    ST_BLD_DIV = 11'b00000100000,
    ST_EM_RD   = 11'b00001000000,
    ST_EM_PIX  = 11'b00010000000,
    ST_EM_MAP  = 11'b00100000000,
    ST_EM_CONV = 11'b01000000000,
    ST_EM_OUT  = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } he_div_stat_t;

  function automatic logic [LVL_W-1:0] he_luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [23:0] s;
    s = 24'(LUMA_R * r) + 24'(LUMA_G * g) + 24'(LUMA_B * b);
    return s[23:16];
  endfunction

  // U numerator stays positive for all inputs
  function automatic logic [7:0] he_chroma_u(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [25:0] s;
    s = 26'(C_OFS) + 26'(CU_B * b) - 26'(CU_R * r) - 26'(CU_G * g);
    return s[23:16];
  endfunction

  // V numerator stays positive for all inputs
  function automatic logic [7:0] he_chroma_v(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [25:0] s;
    s = 26'(C_OFS) + 26'(CV_R * r) - 26'(CV_G * g) - 26'(CV_B * b);
    return s[23:16];
  endfunction

  // Divide by 65536 toward zero, then saturate to the output range
  function automatic logic signed [COL_W-1:0] he_q16_sat(logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] a;
    logic signed [11:0]      q;
    a = -x;
    if (x[ACC_W-1]) begin
      q = -$signed(a[ACC_W-1:16]);
    end else begin
      q = $signed(x[ACC_W-1:16]);
    end
    if (q > 12'sd511) begin
      return 10'sd511;
    end else if (q < -12'sd512) begin
      return -10'sd512;
    end
    return q[COL_W-1:0];
  endfunction

endpackage

@@ rtl/he_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer level divider
// Restoring divider, one quotient bit per cycle, eight-bit quotient.
// ----------------------------------------------------------------------------
module he_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [he_pkg::NUM_W-1:0]  num,
  input  logic [he_pkg::DEN_W-1:0]  den,
  output he_pkg::he_div_stat_t      stat,
  output logic [he_pkg::LVL_W-1:0]  quot
);
  import he_pkg::*;

  logic [NUM_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [2:0]       step_r;
  logic [LVL_W-1:0] q_r;
  logic             busy_r;
  logic             done_r;
  logic [NUM_W:0]   trial;

  // Subtract the divisor aligned to the current quotient bit
  assign trial = {1'b0, rem_r} - ((NUM_W + 1)'(den_r) << step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      done_r <= (step_r == 3'd0);
      busy_r <= (step_r != 3'd0);
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      step_r <= 3'd7;
      q_r    <= '0;
    end else if (busy_r) begin
      if (!trial[NUM_W]) begin
        rem_r <= trial[NUM_W-1:0];
        q_r[step_r] <= 1'b1;
      end
      step_r <= step_r - 3'd1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

@@ rtl/histogram_equalizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer
// Frame buffer with per-frame histogram, level map and luma equalization.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per command; in_tuser is the action (load, emit,
//           new frame), in_tdata carries red/gray, green, blue.
//   out_* : one transaction per emit; signed 10-bit colors packed red lowest, tlast on
//           the final loaded pixel, tuser set when no pixel was left.
//   cfg_* : write color_mode while the block is idle.
// Operation:
//   A load reads the bin, then increments it and writes it back.
//   An emit passes through frame store, level map and color math.
//   The first emit after any load first rebuilds the level map, one level
//   at a time, each level set by the bit-serial divider.
//   A new-frame command clears the bin valid bits at once.
// Reset clears counts, indexes, the map-ready flag and color_mode; the
// frame store and level map hold no reset value.
// A held result stays on out_* until taken; loads and new-frame commands
// continue meanwhile, and the next emit waits for the output register.
// ----------------------------------------------------------------------------
module histogram_equalizer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [he_pkg::IN_TDATA_W-1:0]  in_tdata,   // red_or_gray, green_in, blue_in
  input  logic [1:0]                     in_tuser,   // action
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [he_pkg::OUT_TDATA_W-1:0] out_tdata,  // red_or_gray_out, green_out,
                                                     // blue_out, 2'b0
  output logic                           out_tlast,
  output logic [0:0]                     out_tuser,  // error_flag
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data
);
  import he_pkg::*;

  state_t           state_r;
  logic             color_mode_r;
  logic [CNT_W-1:0] pixel_count_r;
  logic [CNT_W-1:0] read_index_r;
  logic             map_ready_r;

  logic [23:0]      fs_mem [MAX_PIXELS];
  logic [23:0]      fs_rdata_r;
  logic [CNT_W-1:0] bin_mem [LEVELS];
  logic [CNT_W-1:0] bin_rdata_r;
  logic [LEVELS-1:0] bin_vld_r;
  logic             bin_rvld_r;
  logic [LVL_W-1:0] lm_mem [LEVELS];
  logic [LVL_W-1:0] lm_rdata_r;

  logic [LVL_W-1:0] lvl_r;
  logic [LVL_W-1:0] bld_idx_r;
  logic [CNT_W-1:0] cdf_r;
  logic [LVL_W-1:0] y_r, u_r, v_r;
  logic             err_r;
  logic signed [COL_W-1:0] res_r_r, res_g_r, res_b_r;

  logic signed [COL_W-1:0] out_r_r, out_g_r, out_b_r;
  logic             out_valid_r;
  logic             out_last_r;
  logic             out_err_r;

  logic             in_fire;
  action_t          act;
  logic [7:0]       in_red, in_green, in_blue;
  logic [LVL_W-1:0] load_lvl;
  logic             frame_full;
  logic             emit_err;
  logic             do_load;
  logic             bin_re;
  logic [LVL_W-1:0] bin_raddr;
  logic             bin_we;
  logic [CNT_W-1:0] bin_wdata;
  logic             out_free;
  logic [NUM_W-1:0] div_num;
  he_div_stat_t     div_stat;
  logic [LVL_W-1:0] div_q;
  logic [7:0]       px_r, px_g, px_b;
  logic signed [9:0] um, vm;
  logic signed [ACC_W-1:0] y16, acc_r, acc_g, acc_b;

  // Decode the command
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign act        = action_t'(in_tuser);
  assign in_red     = in_tdata[7:0];
  assign in_green   = in_tdata[15:8];
  assign in_blue    = in_tdata[23:16];
  assign load_lvl   = color_mode_r ? he_luma(in_red, in_green, in_blue) : in_red;
  assign frame_full = (pixel_count_r == CNT_W'(MAX_PIXELS));
  assign emit_err   = (pixel_count_r == '0) || (read_index_r >= pixel_count_r);
  assign do_load    = in_fire && (act == ACT_LOAD) && !frame_full;
  assign out_free   = !out_valid_r || out_tready;

  // Histogram bin port: read on load or during map build, write back on load
  assign bin_re    = do_load || (state_r == ST_BLD_RD);
  assign bin_raddr = (state_r == ST_BLD_RD) ? bld_idx_r : load_lvl;
  assign bin_we    = (state_r == ST_LD_BIN);
  assign bin_wdata = (bin_rvld_r ? bin_rdata_r : '0) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[lvl_r] <= bin_wdata;
    end
    if (bin_re) begin
      bin_rdata_r <= bin_mem[bin_raddr];
      bin_rvld_r  <= bin_vld_r[bin_raddr];
    end
  end

  // Frame store
  always_ff @(posedge clk) begin
    if (do_load) begin
      fs_mem[pixel_count_r[PIX_AW-1:0]] <= in_tdata;
    end
    if (state_r == ST_EM_RD) begin
      fs_rdata_r <= fs_mem[read_index_r[PIX_AW-1:0]];
    end
  end

  // Level map
  always_ff @(posedge clk) begin
    if ((state_r == ST_BLD_DIV) && div_stat.done) begin
      lm_mem[bld_idx_r] <= div_q;
    end
    if (state_r == ST_EM_MAP) begin
      lm_rdata_r <= lm_mem[y_r];
    end
  end

  // map = (510*cdf + n) / (2n)
  assign div_num = (NUM_W'(cdf_r) << 9) - (NUM_W'(cdf_r) << 1) + NUM_W'(pixel_count_r);

  he_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_BLD_NUM),
    .num   (div_num),
    .den   ({pixel_count_r, 1'b0}),
    .stat  (div_stat),
    .quot  (div_q)
  );

  // Color conversion back from YUV with the equalized luma
  assign px_r  = fs_rdata_r[7:0];
  assign px_g  = fs_rdata_r[15:8];
  assign px_b  = fs_rdata_r[23:16];
  assign um    = $signed({2'b00, u_r}) - 10'sd128;
  assign vm    = $signed({2'b00, v_r}) - 10'sd128;
  assign y16   = $signed({4'b0000, lm_rdata_r, 16'h0000});
  assign acc_r = y16 + ACC_W'(R_V * vm);
  assign acc_g = y16 - ACC_W'(G_U * um) - ACC_W'(G_V * vm);
  assign acc_b = y16 + ACC_W'(B_U * um);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      color_mode_r  <= 1'b0;
      pixel_count_r <= '0;
      read_index_r  <= '0;
      map_ready_r   <= 1'b0;
      bin_vld_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        color_mode_r <= cfg_wr_data;
      end
      // Drop a taken result unless a new one replaces it
      if (out_valid_r && out_tready && !((state_r == ST_EM_OUT) && out_free)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (act)
              ACT_LOAD: begin
                if (!frame_full) begin
                  pixel_count_r <= pixel_count_r + CNT_W'(1);
                  map_ready_r   <= 1'b0;
                  state_r       <= ST_LD_BIN;
                end
              end
              ACT_EMIT: begin
                if (emit_err) begin
                  state_r <= ST_EM_OUT;
                end else if (!map_ready_r) begin
                  state_r <= ST_BLD_RD;
                end else begin
                  state_r <= ST_EM_RD;
                end
              end
              ACT_NEW_FRAME: begin
                pixel_count_r <= '0;
                read_index_r  <= '0;
                map_ready_r   <= 1'b0;
                bin_vld_r     <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_LD_BIN: begin
          bin_vld_r[lvl_r] <= 1'b1;
          state_r          <= ST_IDLE;
        end
        ST_BLD_RD:  state_r <= ST_BLD_ACC;
        ST_BLD_ACC: state_r <= ST_BLD_NUM;
        ST_BLD_NUM: state_r <= ST_BLD_DIV;
        ST_BLD_DIV: begin
          if (div_stat.done) begin
            if (bld_idx_r == LVL_W'(LEVELS - 1)) begin
              map_ready_r <= 1'b1;
              state_r     <= ST_EM_RD;
            end else begin
              state_r <= ST_BLD_RD;
            end
          end
        end
        ST_EM_RD:   state_r <= ST_EM_PIX;
        ST_EM_PIX:  state_r <= ST_EM_MAP;
        ST_EM_MAP:  state_r <= ST_EM_CONV;
        ST_EM_CONV: state_r <= ST_EM_OUT;
        ST_EM_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (!err_r) begin
              read_index_r <= read_index_r + CNT_W'(1);
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (do_load) begin
      lvl_r <= load_lvl;
    end
    if (in_fire && (act == ACT_EMIT)) begin
      err_r     <= emit_err;
      res_r_r   <= '0;
      res_g_r   <= '0;
      res_b_r   <= '0;
      cdf_r     <= '0;
      bld_idx_r <= '0;
    end
    if (state_r == ST_BLD_ACC) begin
      cdf_r <= cdf_r + (bin_rvld_r ? bin_rdata_r : '0);
    end
    if ((state_r == ST_BLD_DIV) && div_stat.done) begin
      bld_idx_r <= bld_idx_r + LVL_W'(1);
    end
    if (state_r == ST_EM_PIX) begin
      y_r <= color_mode_r ? he_luma(px_r, px_g, px_b) : px_r;
      u_r <= he_chroma_u(px_r, px_g, px_b);
      v_r <= he_chroma_v(px_r, px_g, px_b);
    end
    if (state_r == ST_EM_CONV) begin
      if (color_mode_r) begin
        res_r_r <= he_q16_sat(acc_r);
        res_g_r <= he_q16_sat(acc_g);
        res_b_r <= he_q16_sat(acc_b);
      end else begin
        res_r_r <= $signed({2'b00, lm_rdata_r});
        res_g_r <= '0;
        res_b_r <= '0;
      end
    end
    if ((state_r == ST_EM_OUT) && out_free) begin
      out_r_r    <= res_r_r;
      out_g_r    <= res_g_r;
      out_b_r    <= res_b_r;
      out_err_r  <= err_r;
      out_last_r <= !err_r && ((read_index_r + CNT_W'(1)) == pixel_count_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_b_r, out_g_r, out_r_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

@@ rtl/he_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer port checker
// Watches the top-level ports and flags result channel misbehavior.
// ----------------------------------------------------------------------------
`include "histogram_equalizer_defines.svh"

module he_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [1:0]                     in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [he_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                           out_tlast,
  input logic [0:0]                     out_tuser
);
  import he_pkg::*;

  // Hold a stalled result
  `HE_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped while stalled")

  // Error results carry no pixel
  `HE_ASSERT_IMP(a_err_empty, out_tvalid && out_tuser[0], (out_tdata == '0) && !out_tlast, "error result with payload")

  // Reset leaves the result channel empty
  `HE_ASSERT_RST(a_rst_empty, !rst_n, !out_tvalid, "result valid after reset")

  // A load, new frame or unused action never creates a result
  `HE_ASSERT_NXT(a_load_silent, !out_tvalid && in_tvalid && in_tready && (in_tuser != ACT_EMIT), !out_tvalid, "result without emit")

endmodule

bind histogram_equalizer he_chk u_he_chk (.*);

@@ dv/tb_histogram_equalizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer testbench
// Streams load, emit and new-frame commands through the input channel and
// predicts every emitted pixel from an in-bench equalizer (gray and luma
// modes, map rebuilds, error emits). Both channels idle at random;
// one long receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_histogram_equalizer;
  import he_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] act;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    bit         fast;
  } cmd_t;

  typedef struct {
    logic signed [9:0] r;
    logic signed [9:0] g;
    logic signed [9:0] b;
    logic              last;
    logic              err;
  } pixel_rec_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // red_or_gray, green_in, blue_in
  logic [1:0]  in_tuser;    // action
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // red_or_gray_out, green_out, blue_out, 2'b0
  logic        out_tlast;
  logic [0:0]  out_tuser;   // error_flag
  logic        cfg_wr_en;
  logic        cfg_wr_data;

  histogram_equalizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Equalizer shadow state
  bit          gray_luma_mode;
  int unsigned bin_tally [LEVELS];
  logic [7:0]  eq_map [LEVELS];
  logic [23:0] frame_px [MAX_PIXELS];
  int unsigned loaded_cnt;
  int unsigned emit_idx;
  bit          map_valid;

  cmd_t        pending_cmds [$];
  pixel_rec_t  expected_px [$];
  int          fail_cnt;
  int          queued_cnt;
  int          tx_wait;
  int          rx_wait;
  bit          tx_quiet;
  bit          rx_quiet;
  bit          backlog_armed;
  int          backlog_left;
  logic [7:0]  cluster_base;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int unsigned luma_of(longint r, longint g, longint b);
    return int'((LUMA_R * r + LUMA_G * g + LUMA_B * b) / 65536) & 8'hFF;
  endfunction

  function automatic logic signed [9:0] sat10(longint v);
    if (v > 511) return 10'sd511;
    if (v < -512) return -10'sd512;
    return v[9:0];
  endfunction

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 18));
  endfunction

  // Update the shadow equalizer for one accepted command
  task automatic apply_cmd(cmd_t c);
    pixel_rec_t  e;
    int unsigned lvl;
    longint      cdf, n, pr, pg, pb, y, u, v;
    e = '{default: '0};
    case (c.act)
      ACT_LOAD: begin
        if (loaded_cnt < MAX_PIXELS) begin
          lvl = gray_luma_mode ? luma_of(c.r, c.g, c.b) : c.r;
          frame_px[loaded_cnt] = {c.b, c.g, c.r};
          bin_tally[lvl]++;
          loaded_cnt++;
          map_valid = 0;
        end
      end
      ACT_NEW_FRAME: begin
        foreach (bin_tally[i]) bin_tally[i] = 0;
        loaded_cnt = 0;
        emit_idx = 0;
        map_valid = 0;
      end
      ACT_EMIT: begin
        if (loaded_cnt == 0 || emit_idx >= loaded_cnt) begin
          e.err = 1'b1;
        end else begin
          if (!map_valid) begin
            cdf = 0;
            n = loaded_cnt;
            for (int i = 0; i < LEVELS; i++) begin
              cdf += bin_tally[i];
              eq_map[i] = 8'((MAP_K * cdf + n) / (2 * n));
            end
            map_valid = 1;
          end
          pr = frame_px[emit_idx][7:0];
          pg = frame_px[emit_idx][15:8];
          pb = frame_px[emit_idx][23:16];
          if (gray_luma_mode) begin
            y = eq_map[luma_of(pr, pg, pb)];
            u = (-CU_R * pr - CU_G * pg + CU_B * pb + C_OFS) / 65536;
            v = (CV_R * pr - CV_G * pg - CV_B * pb + C_OFS) / 65536;
            e.r = sat10((y * 65536 + R_V * (v - 128)) / 65536);
            e.g = sat10((y * 65536 - G_U * (u - 128) - G_V * (v - 128)) / 65536);
            e.b = sat10((y * 65536 + B_U * (u - 128)) / 65536);
          end else begin
            e.r = {2'b00, eq_map[pr]};
          end
          e.last = (emit_idx + 1 == loaded_cnt);
          emit_idx++;
        end
        expected_px = {expected_px, e};
      end
      default: ;
    endcase
  endtask

  // Driver: present pending commands with random gaps
  always @(posedge clk) begin
    cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      tx_wait = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        c.act = in_tuser;
        c.r = in_tdata[7:0];
        c.g = in_tdata[15:8];
        c.b = in_tdata[23:16];
        apply_cmd(c);
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        tx_wait = (pending_cmds.size() > 0 && pending_cmds[0].fast) ? 0 : draw_gap(tx_quiet);
      end
      if (!(in_tvalid && !in_tready)) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= c.act;
          in_tdata  <= {c.b, c.g, c.r};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by the first result after arming
  always @(posedge clk) begin
    if (!rst_n) begin
      backlog_left <= 0;
    end else if (backlog_armed && out_tvalid) begin
      backlog_armed = 0;
      backlog_left <= 500;
    end else if (backlog_left > 0) begin
      backlog_left <= backlog_left - 1;
    end
  end

  // Monitor: take results with random stalls and check them
  always @(posedge clk) begin
    pixel_rec_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_px.size() == 0) begin
          $display("%0t: unexpected result tdata=%h last=%b err=%b", $time,
                   out_tdata, out_tlast, out_tuser);
          fail_cnt++;
        end else begin
          e = expected_px.pop_front();
          if (out_tdata[9:0] !== e.r || out_tdata[19:10] !== e.g ||
              out_tdata[29:20] !== e.b || out_tlast !== e.last ||
              out_tuser[0] !== e.err) begin
            $display("%0t: mismatch expected r=%0d g=%0d b=%0d last=%b err=%b", $time,
                     e.r, e.g, e.b, e.last, e.err);
            $display("%0t:          actual   r=%0d g=%0d b=%0d last=%b err=%b", $time,
                     $signed(out_tdata[9:0]), $signed(out_tdata[19:10]),
                     $signed(out_tdata[29:20]), out_tlast, out_tuser[0]);
            fail_cnt++;
          end
        end
        if ($urandom_range(0, 29) == 0) rx_quiet = !rx_quiet;
        rx_wait = draw_gap(rx_quiet);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_tready <= (rx_wait == 0) && (backlog_left == 0) && !backlog_armed;
    end
  end

  task automatic add_cmd(logic [1:0] act, logic [23:0] px, bit fast = 0);
    cmd_t c;
    c.act = act;
    c.r = px[7:0];
    c.g = px[15:8];
    c.b = px[23:16];
    c.fast = fast;
    pending_cmds = {pending_cmds, c};
    queued_cnt++;
  endtask

  function automatic logic [23:0] rand_px();
    logic [23:0] p;
    p = 24'($urandom);
    case ($urandom_range(0, 3))
      1: p = {cluster_base + 8'($urandom_range(0, 15)), cluster_base + 8'($urandom_range(0, 15)),
              cluster_base + 8'($urandom_range(0, 15))};
      2: p = {{8{p[2]}}, {8{p[1]}}, {8{p[0]}}};
      default: ;
    endcase
    return p;
  endfunction

  // Wait until all commands are taken and all results checked
  task automatic drain();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || expected_px.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    gray_luma_mode = m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int k;
    logic [23:0] rgb_dir [7];
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    fail_cnt = 0;
    queued_cnt = 0;
    tx_quiet = 0;
    rx_quiet = 0;
    backlog_armed = 0;
    cluster_base = 8'd40;
    gray_luma_mode = 0;
    loaded_cnt = 0;
    emit_idx = 0;
    map_valid = 0;
    foreach (bin_tally[i]) bin_tally[i] = 0;
    rgb_dir = '{24'h0000FF, 24'h00FF00, 24'hFF0000, 24'hFFFFFF, 24'h000000,
                24'hFF00FF, 24'h00FFFF};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Gray directed: empty emit, unused action, extremes, load after emits
    write_mode(0);
    add_cmd(ACT_EMIT, '0);
    add_cmd(ACT_UNUSED, 24'hFFFFFF);
    add_cmd(ACT_NEW_FRAME, '0);
    add_cmd(ACT_LOAD, 24'h000000);
    add_cmd(ACT_LOAD, 24'hFFFFFF);
    add_cmd(ACT_LOAD, 24'h000080);
    add_cmd(ACT_LOAD, 24'h000080);
    repeat (5) add_cmd(ACT_EMIT, '0);
    add_cmd(ACT_LOAD, 24'h00007F);
    repeat (2) add_cmd(ACT_EMIT, '0);
    drain();

    // RGB directed: primaries, white, black, colors near the range limits
    write_mode(1);
    add_cmd(ACT_NEW_FRAME, '0);
    foreach (rgb_dir[i]) add_cmd(ACT_LOAD, rgb_dir[i]);
    repeat (8) add_cmd(ACT_EMIT, '0);
    drain();

    // Mode switched mid-frame, both ways
    add_cmd(ACT_NEW_FRAME, '0);
    repeat (6) add_cmd(ACT_LOAD, rand_px());
    drain();
    write_mode(0);
    repeat (7) add_cmd(ACT_EMIT, '0);
    add_cmd(ACT_NEW_FRAME, '0);
    repeat (6) add_cmd(ACT_LOAD, rand_px());
    drain();
    write_mode(1);
    repeat (7) add_cmd(ACT_EMIT, '0);
    drain();

    // Back up the block: results held while loads and emits keep coming
    backlog_armed = 1;
    add_cmd(ACT_NEW_FRAME, '0);
    repeat (8) add_cmd(ACT_LOAD, rand_px());
    repeat (3) add_cmd(ACT_EMIT, '0);
    repeat (6) add_cmd(ACT_LOAD, rand_px());
    repeat (12) add_cmd(ACT_EMIT, '0);
    drain();

    // Random frames, mostly well formed
    while (queued_cnt < 1100) begin
      if ($urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));
      cluster_base = 8'($urandom_range(0, 240));
      if ($urandom_range(0, 7) != 0) add_cmd(ACT_NEW_FRAME, '0);
      k = $urandom_range(1, 24);
      repeat (k) begin
        add_cmd(ACT_LOAD, rand_px());
        if ($urandom_range(0, 19) == 0) add_cmd(ACT_UNUSED, 24'($urandom));
      end
      repeat ($urandom_range(0, k + 1)) begin
        add_cmd(ACT_EMIT, '0);
        if ($urandom_range(0, 24) == 0) add_cmd(ACT_LOAD, rand_px());
        if ($urandom_range(0, 59) == 0) add_cmd(ACT_NEW_FRAME, '0);
      end
      if ($urandom_range(0, 3) == 0) repeat (k + 2) add_cmd(ACT_EMIT, '0);
      drain();
    end

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
